FILE: rtl/mwba_pkg.sv
// Shared types and constants of the multi-window bucket averager.
`default_nettype none
package mwba_pkg;

    localparam int DVD_W     = 42;   // time in ms and sum magnitude
    localparam int DSR_W     = 26;   // bucket period or sample count
    localparam int VAL_W     = 24;   // Q16.8 value
    localparam int SUM_W     = 40;
    localparam int CNT_W     = 16;
    localparam int TIME_W    = 32;
    localparam int LANE_W    = VAL_W + 1;   // valid flag over value
    localparam int IDX_IN_W  = 7;
    localparam int SEL_W     = 2;
    localparam int CFG_NUM   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;
    localparam logic [9:0]       MS_PER_S  = 10'd1000;

    localparam logic [DSR_W-1:0] HOUR_MS_RST = 26'd37500;
    localparam logic [DSR_W-1:0] DAY_MS_RST  = 26'd900000;
    localparam logic [DSR_W-1:0] WEEK_MS_RST = 26'd6300000;

    localparam logic [CFG_IDX_W-1:0] CFG_HOUR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DAY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEEK = 2'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_BDIV,
        S_BWAIT,
        S_CHECK,
        S_ADIV,
        S_AWAIT,
        S_PUSH,
        S_GAP,
        S_ACC,
        S_NEXTW,
        S_RSEL,
        S_RMEM,
        S_RGET,
        S_RDIV,
        S_RWAIT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

FILE: rtl/multi_window_bucket_averager_core.sv
// Top level of the multi-window bucket averager.
// Sequence: an add forms the ms product, then the bucket divide for each window; on a bucket
//   change it divides each metric sum that has samples for its average and writes the ring
//   (a push, then gap rows, gap at most POINTS); then the result is loaded. A read takes a
//   stored point or divides the live sum. One beat at a time; quotients share one divider.
// Reset: synchronous, active low; then a clearing pass over all WINDOWS*POINTS memory rows.
`default_nettype none
module multi_window_bucket_averager_core
    import mwba_pkg::*;
#(
    parameter int POINTS  = 96,
    parameter int METRICS = 4,
    parameter int WINDOWS = 3
)(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic                  i_command,
    input  wire logic [TIME_W-1:0]     i_time_s,
    input  wire logic signed [VAL_W-1:0] i_value_0,
    input  wire logic signed [VAL_W-1:0] i_value_1,
    input  wire logic signed [VAL_W-1:0] i_value_2,
    input  wire logic signed [VAL_W-1:0] i_value_3,
    input  wire logic [3:0]            i_value_valid,
    input  wire logic [SEL_W-1:0]      i_window_select,
    input  wire logic [SEL_W-1:0]      i_metric_select,
    input  wire logic [IDX_IN_W-1:0]   i_point_index,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic                       o_bucket_closed,
    output logic signed [VAL_W-1:0]    o_point_value,
    output logic                       o_point_valid,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [DSR_W-1:0]      i_cfg_data
);

    localparam int PW     = (POINTS > 2) ? $clog2(POINTS) : 1;
    localparam int GW     = $clog2(POINTS + 1);
    localparam int WW     = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam int MW     = (METRICS > 1) ? $clog2(METRICS) : 1;
    localparam int ROWS   = WINDOWS * POINTS;
    localparam int ADDR_W = $clog2(ROWS);
    localparam int ROW_W  = METRICS * LANE_W;

    t_state r_state, n_state;

    // configuration registers
    logic [DSR_W-1:0] r_cfg [CFG_NUM];

    // captured beat
    logic                    r_cmd;
    logic [TIME_W-1:0]       r_time;
    logic signed [VAL_W-1:0] r_vals [METRICS];
    logic [METRICS-1:0]      r_vv;
    logic [SEL_W-1:0]        r_rwin;
    logic [SEL_W-1:0]        r_rmet;
    logic [IDX_IN_W-1:0]     r_ridx;

    // window state
    logic [DVD_W-1:0]        r_cur [WINDOWS];
    logic [WINDOWS-1:0]      r_started;
    logic [PW-1:0]           r_wp [WINDOWS];
    logic signed [SUM_W-1:0] r_sum [WINDOWS][METRICS];
    logic [CNT_W-1:0]        r_cnt [WINDOWS][METRICS];

    // sequencer working registers
    logic [WW-1:0]       r_w;
    logic [MW-1:0]       r_m;
    logic [DVD_W-1:0]    r_ms;
    logic [DVD_W-1:0]    r_bucket;
    logic [GW-1:0]       r_gap;
    logic                r_closed;
    logic                r_neg;
    logic [LANE_W-1:0]   r_row [METRICS];
    logic [ADDR_W-1:0]   r_clr;
    logic [ADDR_W-1:0]   r_raddr;
    logic                r_res_vld;
    logic [VAL_W-1:0]    r_res_val;

    // output register
    logic                r_ovalid;
    logic                r_o_closed;
    logic [VAL_W-1:0]    r_o_val;
    logic                r_o_vld;

    // divider and memory hookup
    logic                div_start;
    logic [DVD_W-1:0]    div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic                div_done;
    logic [DVD_W-1:0]    div_q;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;
    logic [ROW_W-1:0]    mem_rdata;
    logic [ROW_W-1:0]    row_packed;

    logic signed [SUM_W-1:0] cur_sum;
    logic [CNT_W-1:0]        cur_cnt;
    logic [SUM_W-1:0]        sum_mag;
    logic [DSR_W-1:0]        period;
    logic signed [DVD_W:0]   gap_diff;
    logic [GW-1:0]           gap_next;
    logic [ADDR_W-1:0]       wr_row;
    logic [ADDR_W-1:0]       rd_row;
    logic [PW-1:0]           wp_inc;
    logic [VAL_W-1:0]        avg_val;
    logic [LANE_W-1:0]       rd_lane;
    logic [WW-1:0]           rsel_w;
    logic                    rsel_bad;
    logic                    rsel_live;
    logic                    out_load;
    logic                    in_take;

    assign in_take  = i_valid && !o_stall;
    assign out_load = (r_state == S_DONE) && (!r_ovalid || !i_stall);

    // ---------------------------------------------------------------
    // Shared datapath terms
    // ---------------------------------------------------------------
    always_comb begin
        int slot;
        // hour window for a select out of range
        rsel_w    = (int'(r_rwin) >= WINDOWS || r_rwin == 2'd3) ? '0 : WW'(r_rwin);
        rsel_bad  = (int'(r_rmet) >= METRICS) || (int'(r_ridx) >= POINTS);
        rsel_live = (int'(r_ridx) == POINTS - 1);

        // oldest shown point sits just after the write position of the selected window
        slot     = int'(r_wp[rsel_w]) + 1 + int'(r_ridx);
        if (slot >= POINTS) begin
            slot = slot - POINTS;
        end
        rd_row   = ADDR_W'(int'(rsel_w) * POINTS + slot);

        cur_sum  = r_sum[r_w][r_m];
        cur_cnt  = r_cnt[r_w][r_m];
        sum_mag  = cur_sum[SUM_W-1] ? SUM_W'(-cur_sum) : SUM_W'(cur_sum);
        period   = (r_cfg[r_w] == '0) ? DSR_W'(1) : r_cfg[r_w];

        // skipped buckets, none when the clock went back
        gap_diff = $signed({1'b0, r_bucket}) - $signed({1'b0, r_cur[r_w]})
                 - $signed((DVD_W+1)'(1));
        if (gap_diff[DVD_W]) begin
            gap_next = '0;
        end else if (gap_diff > $signed((DVD_W+1)'(POINTS))) begin
            gap_next = GW'(POINTS);
        end else begin
            gap_next = GW'(gap_diff);
        end

        wr_row   = ADDR_W'(int'(r_w) * POINTS + int'(r_wp[r_w]));
        wp_inc   = (r_wp[r_w] == PW'(POINTS - 1)) ? '0 : r_wp[r_w] + 1'b1;
        avg_val  = r_neg ? VAL_W'(-div_q[VAL_W-1:0]) : div_q[VAL_W-1:0];
        rd_lane  = mem_rdata[r_m*LANE_W +: LANE_W];

        for (int m = 0; m < METRICS; m++) begin
            row_packed[m*LANE_W +: LANE_W] = r_row[m];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state and unit controls
    // ---------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_dvd   = r_ms;
        div_dsr   = period;
        mem_we    = 1'b0;
        mem_waddr = wr_row;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == ADDR_W'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_command == CMD_READ) ? S_RSEL : S_MUL;
                end
            end
            S_MUL:   n_state = S_BDIV;
            S_BDIV: begin
                div_start = 1'b1;
                n_state   = S_BWAIT;
            end
            S_BWAIT: begin
                if (div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_started[r_w] && r_bucket != r_cur[r_w]) begin
                    n_state = S_ADIV;
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ADIV: begin
                if (cur_cnt != '0) begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(sum_mag);
                    div_dsr   = DSR_W'(cur_cnt);
                    n_state   = S_AWAIT;
                end else if (int'(r_m) == METRICS - 1) begin
                    n_state = S_PUSH;
                end
            end
            S_AWAIT: begin
                if (div_done) begin
                    n_state = (int'(r_m) == METRICS - 1) ? S_PUSH : S_ADIV;
                end
            end
            S_PUSH: begin
                mem_we    = 1'b1;
                mem_wdata = row_packed;
                n_state   = S_GAP;
            end
            S_GAP: begin
                if (r_gap == '0) begin
                    n_state = S_ACC;
                end else begin
                    mem_we = 1'b1;
                end
            end
            S_ACC:   n_state = S_NEXTW;
            S_NEXTW: begin
                n_state = (int'(r_w) == WINDOWS - 1) ? S_DONE : S_BDIV;
            end
            S_RSEL: begin
                if (rsel_bad) begin
                    n_state = S_DONE;
                end else if (rsel_live) begin
                    n_state = S_RDIV;
                end else begin
                    n_state = S_RMEM;
                end
            end
            S_RMEM:  n_state = S_RGET;
            S_RGET:  n_state = S_DONE;
            S_RDIV: begin
                if (cur_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(sum_mag);
                    div_dsr   = DSR_W'(cur_cnt);
                    n_state   = S_RWAIT;
                end
            end
            S_RWAIT: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_HOUR] <= HOUR_MS_RST;
            r_cfg[CFG_DAY]  <= DAY_MS_RST;
            r_cfg[CFG_WEEK] <= WEEK_MS_RST;
        end else if (i_cfg_valid && o_cfg_ready && int'(i_cfg_index) < CFG_NUM) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // ---------------------------------------------------------------
    // Window state and working registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_started <= '0;
            r_w       <= '0;
            r_m       <= '0;
            r_gap     <= '0;
            for (int w = 0; w < WINDOWS; w++) begin
                r_cur[w] <= '0;
                r_wp[w]  <= '0;
                for (int m = 0; m < METRICS; m++) begin
                    r_sum[w][m] <= '0;
                    r_cnt[w][m] <= '0;
                end
            end
        end else begin
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE: begin
                    if (in_take) begin
                        r_cmd    <= i_command;
                        r_time   <= i_time_s;
                        r_vv     <= i_value_valid[METRICS-1:0];
                        r_rwin   <= i_window_select;
                        r_rmet   <= i_metric_select;
                        r_ridx   <= i_point_index;
                        r_w      <= '0;
                        r_m      <= '0;
                        r_closed <= 1'b0;
                        r_res_vld <= 1'b0;
                        r_res_val <= '0;
                        r_vals[0] <= i_value_0;
                        if (METRICS > 1) r_vals[1 % METRICS] <= i_value_1;
                        if (METRICS > 2) r_vals[2 % METRICS] <= i_value_2;
                        if (METRICS > 3) r_vals[3 % METRICS] <= i_value_3;
                    end
                end
                S_MUL: r_ms <= DVD_W'({10'd0, r_time} * {32'd0, MS_PER_S});
                S_BDIV: r_m <= '0;
                S_BWAIT: begin
                    if (div_done) begin
                        r_bucket <= div_q;
                    end
                end
                S_CHECK: begin
                    // the first add opens its bucket without a push
                    if (!r_started[r_w]) begin
                        r_started[r_w] <= 1'b1;
                        r_cur[r_w]     <= r_bucket;
                    end else if (r_bucket != r_cur[r_w]) begin
                        r_gap      <= gap_next;
                        r_cur[r_w] <= r_bucket;
                        r_closed   <= 1'b1;
                    end
                end
                S_ADIV: begin
                    r_neg <= cur_sum[SUM_W-1];
                    if (cur_cnt == '0) begin
                        r_row[r_m] <= '0;
                        if (int'(r_m) != METRICS - 1) begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                end
                S_AWAIT: begin
                    if (div_done) begin
                        r_row[r_m] <= {1'b1, avg_val};
                        if (int'(r_m) != METRICS - 1) begin
                            r_m <= r_m + 1'b1;
                        end
                    end
                end
                S_PUSH: begin
                    r_wp[r_w] <= wp_inc;
                    for (int m = 0; m < METRICS; m++) begin
                        r_sum[r_w][m] <= '0;
                        r_cnt[r_w][m] <= '0;
                    end
                end
                S_GAP: begin
                    if (r_gap != '0) begin
                        r_wp[r_w] <= wp_inc;
                        r_gap     <= r_gap - 1'b1;
                    end
                end
                S_ACC: begin
                    // drop readings once the count saturates
                    for (int m = 0; m < METRICS; m++) begin
                        if (r_vv[m] && r_cnt[r_w][m] != CNT_MAX) begin
                            r_sum[r_w][m] <= r_sum[r_w][m] + SUM_W'(r_vals[m]);
                            r_cnt[r_w][m] <= r_cnt[r_w][m] + 1'b1;
                        end
                    end
                end
                S_NEXTW: begin
                    if (int'(r_w) != WINDOWS - 1) begin
                        r_w <= r_w + 1'b1;
                    end
                end
                S_RSEL: begin
                    r_w     <= rsel_w;
                    r_m     <= MW'(r_rmet);
                    r_raddr <= rd_row;
                end
                S_RGET: begin
                    r_res_vld <= rd_lane[VAL_W];
                    r_res_val <= rd_lane[VAL_W] ? rd_lane[VAL_W-1:0] : '0;
                end
                S_RDIV: r_neg <= cur_sum[SUM_W-1];
                S_RWAIT: begin
                    if (div_done) begin
                        r_res_vld <= 1'b1;
                        r_res_val <= avg_val;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Result register: holds one beat while the next item is worked on
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_closed <= (r_cmd == CMD_ADD) && r_closed;
            r_o_vld    <= (r_cmd == CMD_READ) && r_res_vld;
            r_o_val    <= (r_cmd == CMD_READ) ? r_res_val : '0;
        end
    end

    mwba_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dsr),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    mwba_store #(
        .ROWS   (ROWS),
        .ROW_W  (ROW_W),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_ovalid;
    assign o_bucket_closed = r_o_closed;
    assign o_point_value   = r_o_val;
    assign o_point_valid   = r_o_vld;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_BWAIT || r_state == S_AWAIT || r_state == S_RWAIT))
        else $error("divider finished outside a wait state");

    a_gap_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gap <= GW'(POINTS))
        else $error("gap count above ring depth");

    a_wp_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_wp[r_w]) < POINTS)
        else $error("write position past ring end");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_o_closed) |-> !r_o_vld)
        else $error("add beat carries a read point");

    a_load_follows_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result appeared without finished item");

endmodule
`default_nettype wire

FILE: rtl/mwba_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mwba_div
    import mwba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient
);

    localparam int CW = $clog2(DVD_W + 1);

    logic             r_busy;
    logic [CW-1:0]    r_cnt;
    logic [DSR_W-1:0] r_rem;
    logic [DSR_W-1:0] r_dsr;
    logic [DVD_W-1:0] r_q;
    logic             r_done;
    logic [DSR_W:0]   shifted;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_q[DVD_W-1]};
        ge      = shifted >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                // shift in the next dividend bit, subtract when it fits
                r_rem <= ge ? DSR_W'(shifted - {1'b0, r_dsr}) : shifted[DSR_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule
`default_nettype wire

FILE: rtl/mwba_store.sv
// History point memory: one write port, one registered read port.
`default_nettype none
module mwba_store
    import mwba_pkg::*;
#(
    parameter int ROWS   = 288,
    parameter int ROW_W  = 100,
    parameter int ADDR_W = 9
)(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [ROW_W-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic [ROW_W-1:0]       o_rdata
);

    logic [ROW_W-1:0] mem [ROWS];
    logic [ROW_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire
